FILE: src/assert_macros.svh
// Assertion macros for the checker file of the project.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion violated");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

FILE: src/b64enc_pkg.sv
// Package of the base64 stream encoder: group type, constants and the
// sextet-to-character mapping. No dependencies.
`default_nettype none

package b64enc_pkg;

   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] PadChar = 8'h3D;

   typedef enum logic [1:0] {
      PHASE_EMPTY = 2'd0,
      PHASE_ONE   = 2'd1,
      PHASE_TWO   = 2'd2,
      PHASE_BAD   = 2'd3
   } phase_type;

   // One closed group of up to three bytes, left aligned in word.
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  nbytes;
      logic        last;
   } group_type;

   function automatic logic [7:0] b64_char(input logic [5:0] sextet);
      logic [7:0] ch;
      ch = 8'h2F;
      if (sextet < 6'd26) begin
         ch = 8'h41 + {2'b00, sextet};
      end else if (sextet < 6'd52) begin
         ch = 8'h61 + {2'b00, sextet - 6'd26};
      end else if (sextet < 6'd62) begin
         ch = 8'h30 + {2'b00, sextet - 6'd52};
      end else if (sextet == 6'd62) begin
         ch = 8'h2B;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: src/b64enc_front.sv
// Front end of the base64 encoder: collects bytes into groups of three,
// or into shorter groups closed by in_final. Depends on b64enc_pkg.
`default_nettype none

module b64enc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_final,
   output logic                      grp_push,
   output b64enc_pkg::group_type     grp_data
);

   b64enc_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;

   // An out-of-range phase behaves as an empty group.
   assign phase_eff = (phase_ff == b64enc_pkg::PHASE_BAD) ? b64enc_pkg::PHASE_EMPTY : phase_ff;

   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      grp_push  = 1'b0;
      grp_data.last = in_final;
      unique case (phase_eff)
         b64enc_pkg::PHASE_ONE: begin
            grp_data.word   = {first_ff, in_byte, 8'h00};
            grp_data.nbytes = 2'd2;
         end
         b64enc_pkg::PHASE_TWO: begin
            grp_data.word   = {first_ff, second_ff, in_byte};
            grp_data.nbytes = 2'd3;
         end
         default: begin
            grp_data.word   = {in_byte, 16'h0000};
            grp_data.nbytes = 2'd1;
         end
      endcase
      if (in_valid) begin
         if (!in_final && phase_eff != b64enc_pkg::PHASE_TWO) begin
            if (phase_eff == b64enc_pkg::PHASE_EMPTY) begin
               first_in = in_byte;
               phase_in = b64enc_pkg::PHASE_ONE;
            end else begin
               second_in = in_byte;
               phase_in  = b64enc_pkg::PHASE_TWO;
            end
         end else begin
            grp_push  = 1'b1;
            phase_in  = b64enc_pkg::PHASE_EMPTY;
            first_in  = 8'h00;
            second_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= b64enc_pkg::PHASE_EMPTY;
         first_ff  <= 8'h00;
         second_ff <= 8'h00;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/b64enc_queue.sv
// Short queue of closed groups between the front and back of the encoder.
// Depends on b64enc_pkg.
`default_nettype none

module b64enc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire b64enc_pkg::group_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output b64enc_pkg::group_type     head
);

   b64enc_pkg::group_type mem_ff [b64enc_pkg::QueueDepth];
   logic [b64enc_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64enc_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64enc_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == b64enc_pkg::QueueCountWidth'(b64enc_pkg::QueueDepth));
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64enc_pkg::QueuePtrWidth'(b64enc_pkg::QueueDepth - 1)) ?
                     '0 : b64enc_pkg::QueuePtrWidth'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64enc_pkg::QueuePtrWidth'(b64enc_pkg::QueueDepth - 1)) ?
                     '0 : b64enc_pkg::QueuePtrWidth'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = b64enc_pkg::QueueCountWidth'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = b64enc_pkg::QueueCountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/b64enc_back.sv
// Back end of the base64 encoder: turns one group into four characters,
// one per cycle while the output register is popped or empty, into that register. Depends on b64enc_pkg.
`default_nettype none

module b64enc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 grp_valid,
   input  wire b64enc_pkg::group_type grp_head,
   output logic                      grp_pop,
   output logic                      out_valid,
   output logic [7:0]                out_char,
   output logic                      out_eot,
   input  wire logic                 out_pop
);

   b64enc_pkg::group_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_eot_ff, out_eot_in;
   logic       advance, finishing;
   logic [5:0] sextet;
   logic       pad;

   assign advance   = cur_valid_ff && (!out_valid_ff || out_pop);
   assign finishing = advance && (idx_ff == 2'd3);
   assign grp_pop   = grp_valid && (!cur_valid_ff || finishing);

   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            sextet = cur_ff.word[23:18];
            pad    = 1'b0;
         end
         2'd1: begin
            sextet = cur_ff.word[17:12];
            pad    = 1'b0;
         end
         2'd2: begin
            sextet = cur_ff.word[11:6];
            pad    = (cur_ff.nbytes < 2'd2);
         end
         default: begin
            sextet = cur_ff.word[5:0];
            pad    = (cur_ff.nbytes < 2'd3);
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_eot_in   = out_eot_ff;
      if (out_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = pad ? b64enc_pkg::PadChar : b64enc_pkg::b64_char(sextet);
         out_eot_in   = (idx_ff == 2'd3) && cur_ff.last;
         idx_in       = 2'(idx_ff + 2'd1);
         if (idx_ff == 2'd3) begin
            cur_valid_in = 1'b0;
         end
      end
      if (grp_pop) begin
         cur_in       = grp_head;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_eot_ff  <= out_eot_in;
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_eot   = out_eot_ff;

endmodule

`default_nettype wire

FILE: src/base64_stream_encoder_core.sv
// Base64 stream encoder (standard alphabet with '=' padding). A byte is taken
// in every cycle in which req_push is high and req_full is low; a group of three
// bytes, or a shorter group closed by req_final_byte, becomes four characters,
// and the last character of a message carries rsp_end_of_text. The back end
// delivers one character per cycle while rsp_pop takes them, and the front keeps
// taking bytes while the back end works; req_full rises when the two-entry group
// queue fills. A closed group passes through the group queue and the back end's
// group register before its first character reaches the output register. Depends
// on b64enc_pkg and the front, queue and back modules.
`default_nettype none

module base64_stream_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_end_of_text
);

   logic                  accept;
   logic                  grp_push;
   b64enc_pkg::group_type grp_data;
   logic                  q_full;
   logic                  q_valid;
   logic                  q_pop;
   b64enc_pkg::group_type q_head;
   logic                  out_valid;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign rsp_empty = !out_valid;

   b64enc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_data_byte),
      .in_final (req_final_byte),
      .grp_push (grp_push),
      .grp_data (grp_data)
   );

   b64enc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (q_valid),
      .grp_head  (q_head),
      .grp_pop   (q_pop),
      .out_valid (out_valid),
      .out_char  (rsp_out_char),
      .out_eot   (rsp_end_of_text),
      .out_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

FILE: src/b64enc_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends on assert_macros.svh and base64_stream_encoder_core.
`default_nettype none
`include "assert_macros.svh"

module b64enc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [7:0]  rsp_out_char,
   input wire logic        rsp_end_of_text
);

   logic       rsp_stall;
   logic [8:0] rsp_word;
   logic       char_ok;
   logic       pad_taken;

   assign rsp_stall = !rsp_empty && !rsp_pop;
   assign rsp_word  = {rsp_out_char, rsp_end_of_text};
   assign char_ok   = (rsp_out_char >= 8'h41 && rsp_out_char <= 8'h5A) ||
                      (rsp_out_char >= 8'h61 && rsp_out_char <= 8'h7A) ||
                      (rsp_out_char >= 8'h30 && rsp_out_char <= 8'h39) ||
                      rsp_out_char == 8'h2B || rsp_out_char == 8'h2F ||
                      rsp_out_char == 8'h3D;
   assign pad_taken = !rsp_empty && rsp_pop && rsp_out_char == 8'h3D && !rsp_end_of_text;

   // A waiting result that is not taken stays as it is.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, !rsp_empty && $stable(rsp_word))

   // Every character shown is from the base64 alphabet or the pad.
   `ASSERT_IMPLIES(a_rsp_alphabet, clock, reset, !rsp_empty, char_ok)

   // The block comes out of reset with nothing to deliver and room for input.
   `ASSERT_IMPLIES(a_rsp_reset_empty, clock, reset, $past(reset), rsp_empty && !req_full)

   // A pad that is transferred without the end mark is followed by a second pad.
   `ASSERT_NEXT(a_pad_pair, clock, reset, pad_taken, rsp_empty || rsp_out_char == 8'h3D)

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (.*);

`default_nettype wire

FILE: dv/tb_base64_stream_encoder_core.sv
// Testbench for base64_stream_encoder_core: directed and random byte streams,
// with every encoded character checked against an in-bench encoder.
// Depends on b64enc_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;

   localparam logic [8*64-1:0] B64Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int TimeoutNs = 5_000_000;
   localparam int DrainCycles = 20;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
   } encoded_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_out_char;
   logic       rsp_end_of_text;

   // Encoder state as the block should hold it.
   b64enc_pkg::phase_type group_phase = b64enc_pkg::PHASE_EMPTY;
   logic [7:0] held_first = 8'h00;
   logic [7:0] held_second = 8'h00;

   encoded_char_type awaited_chars[$];

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int rsp_hold_cycles = 0;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned messages_closed = 0;

   base64_stream_encoder_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_end_of_text (rsp_end_of_text)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
      return B64Alphabet[8*(63 - sextet) +: 8];
   endfunction

   function automatic void queue_char(input logic [7:0] ch, input logic eot);
      encoded_char_type item;
      item.ch = ch;
      item.eot = eot;
      awaited_chars.push_back(item);
   endfunction

   // Advances the encoder state by one byte and queues the characters it closes.
   function automatic void encode_byte(input logic [7:0] data, input logic last);
      b64enc_pkg::phase_type phase;
      logic [23:0] word;
      int         nbytes;
      phase = (group_phase == b64enc_pkg::PHASE_BAD) ? b64enc_pkg::PHASE_EMPTY : group_phase;
      if (!last && phase != b64enc_pkg::PHASE_TWO) begin
         if (phase == b64enc_pkg::PHASE_EMPTY) begin
            held_first = data;
            group_phase = b64enc_pkg::PHASE_ONE;
         end else begin
            held_second = data;
            group_phase = b64enc_pkg::PHASE_TWO;
         end
         return;
      end
      case (phase)
         b64enc_pkg::PHASE_EMPTY: begin
            word = {data, 16'h0000};
            nbytes = 1;
         end
         b64enc_pkg::PHASE_ONE: begin
            word = {held_first, data, 8'h00};
            nbytes = 2;
         end
         default: begin
            word = {held_first, held_second, data};
            nbytes = 3;
         end
      endcase
      queue_char(sextet_char(word[23:18]), 1'b0);
      queue_char(sextet_char(word[17:12]), 1'b0);
      queue_char((nbytes > 1) ? sextet_char(word[11:6]) : b64enc_pkg::PadChar, 1'b0);
      queue_char((nbytes > 2) ? sextet_char(word[5:0]) : b64enc_pkg::PadChar, last);
      group_phase = b64enc_pkg::PHASE_EMPTY;
      held_first = 8'h00;
      held_second = 8'h00;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Offers one byte, possibly after an idle burst, and returns once it is taken.
   task automatic send_byte(input logic [7:0] data, input logic last);
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_final_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      encode_byte(data, last);
      bytes_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (awaited_chars.size() != 0);
   endtask

   // Groups of one, two and three bytes, with and without the final flag,
   // and bytes that reach both ends of the alphabet.
   task automatic test_directed_groups();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b0);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b1);
      send_byte(8'h4D, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      wait_for_drain();
   endtask

   // The reader stops for a long stretch while bytes keep coming, so the
   // group queue fills and the input side has to stall.
   task automatic test_full_backpressure();
      send_idle_on = 1'b0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 8; i++) begin
         send_message(3);
      end
      send_idle_on = 1'b1;
      wait_for_drain();
   endtask

   task automatic test_random_stream();
      int unsigned start;
      int len;
      start = bytes_sent;
      while (bytes_sent - start < 380) begin
         if ($urandom_range(0, 9) < 8) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            send_message(len);
         end else begin
            // Loose bytes with the flag set at random.
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // Both sides run flat out for the closing part of the run.
   task automatic test_back_to_back();
      int unsigned start;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      start = bytes_sent;
      while (bytes_sent - start < 40) begin
         send_message($urandom_range(1, 6));
      end
   endtask

   // Result side: random pops, plus one long hold-off when a test asks for it.
   initial begin
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      encoded_char_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h eot %0b",
                                      rsp_out_char, rsp_end_of_text));
         end else begin
            want = awaited_chars.pop_front();
            chars_checked++;
            if (want.eot) messages_closed++;
            if (rsp_out_char !== want.ch) begin
               report_mismatch($sformatf("character %0d: got 0x%02h, want 0x%02h",
                                         chars_checked, rsp_out_char, want.ch));
            end
            if (rsp_end_of_text !== want.eot) begin
               report_mismatch($sformatf("character %0d: end_of_text %0b, want %0b",
                                         chars_checked, rsp_end_of_text, want.eot));
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_groups();
      test_full_backpressure();
      test_random_stream();
      test_back_to_back();
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d bytes; checked %0d characters closing %0d messages.",
               bytes_sent, chars_checked, messages_closed);
      $display("Covered padded and full groups, a full-queue stall and idle-free traffic.");
      if (error_count == 0) begin
         $display("tb_base64_stream_encoder_core: PASS");
      end else begin
         $display("tb_base64_stream_encoder_core: FAIL");
      end
      $finish;
   end

   initial begin
      #(TimeoutNs);
      $display("Timeout with %0d characters still awaited.", awaited_chars.size());
      $display("tb_base64_stream_encoder_core: FAIL");
      $finish;
   end

endmodule
